// ----- rtl/core/mtsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mtsc_pkg;

    localparam int unsigned MT_N     = 624;
    localparam int unsigned MT_M     = 397;
    localparam int unsigned MT_GAP   = MT_N - MT_M;
    localparam int unsigned IDX_W    = $clog2(MT_N);
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KEY_W    = 16;
    localparam int unsigned BYTE_W   = 8;

    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7FFF_FFFF;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_TW_PRE,
        ST_TW_LD,
        ST_TW_RD,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_TMP,
        ST_EMIT
    } mtsc_state_t;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        word_t wdata;
        idx_t  raddr_a;
        idx_t  raddr_b;
    } mtsc_ram_req_t;

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mtsc_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mtsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_message;

    modport source (output valid, output data_byte, output start_of_message, input ready);
    modport sink (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface mtsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mtsc_state_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mtsc_state_ram (
    input  wire logic                  clk,
    input  wire mtsc_pkg::mtsc_ram_req_t req,
    output logic [mtsc_pkg::WORD_W-1:0] rdata_a,
    output logic [mtsc_pkg::WORD_W-1:0] rdata_b
);

    logic [mtsc_pkg::WORD_W-1:0] mem [0:mtsc_pkg::MT_N-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[req.raddr_a];
        rdata_b <= mem[req.raddr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/core/mt19937_stream_cipher_core.sv -----
// MT19937 keystream XOR cipher, one byte per transfer.
// Channels: data (sink) carries data_byte and start_of_message; result
// (source) carries out_byte, one result per input transfer, in order.
// cfg_we/cfg_wdata write the 16-bit seed key; it is used at the next start
// of message. The first item after reset always reseeds.
// Work per item, from one input transfer to the next while the receiver keeps
// up (the result turns valid back in idle, before the next input is taken):
//   for the second to fourth byte of a generator word, the byte is emitted;
//   when a new word is fetched: one read of the state RAM, then tempering;
//   when the 624-word state has run out, a twist comes first: after the reads
//   are primed, each step reads two words and writes one;
//   on a reseed, the state is seeded first: the init multiply is registered.
// The generator state lives in a 624 x 32 RAM with one write and two
// registered read ports; the sequencer never reads the word that it writes
// in that cycle. The next item is taken once the current one is finished, even
// while its result still waits; a stalled receiver holds the result register
// and the block waits before writing the next result.
// Reset clears the control state and the key; the state RAM is not cleared,
// it is always seeded before it is read.
`timescale 1ns / 1ps
`default_nettype none

module mt19937_stream_cipher_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mtsc_in_if.sink                          data,
    mtsc_out_if.source                       result,
    input  wire logic                        cfg_we,
    input  wire logic [mtsc_pkg::KEY_W-1:0]  cfg_wdata
);

    localparam mtsc_pkg::idx_t IDX_LAST = mtsc_pkg::IDX_W'(mtsc_pkg::MT_N - 1);
    localparam mtsc_pkg::idx_t IDX_FULL = mtsc_pkg::IDX_W'(mtsc_pkg::MT_N);
    localparam mtsc_pkg::idx_t IDX_GAP  = mtsc_pkg::IDX_W'(mtsc_pkg::MT_GAP);
    localparam mtsc_pkg::idx_t IDX_M    = mtsc_pkg::IDX_W'(mtsc_pkg::MT_M);

    mtsc_pkg::mtsc_state_t state_reg, state_next;

    logic [mtsc_pkg::KEY_W-1:0]  key_reg;
    logic                        seeded_reg, seeded_next;
    mtsc_pkg::idx_t              k_reg, k_next;
    mtsc_pkg::idx_t              word_pos_reg, word_pos_next;
    logic [1:0]                  byte_pos_reg, byte_pos_next;
    mtsc_pkg::word_t             prev_reg, prev_next;
    mtsc_pkg::word_t             prod_reg, prod_next;
    mtsc_pkg::word_t             cur_reg, cur_next;
    mtsc_pkg::word_t             tempered_reg, tempered_next;
    logic [mtsc_pkg::BYTE_W-1:0] data_reg, data_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mtsc_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;

    mtsc_pkg::mtsc_ram_req_t     ram_req;
    mtsc_pkg::word_t             rd_a, rd_b;

    logic                        accept;
    logic                        reseed;
    logic                        out_free;
    mtsc_pkg::idx_t              k_nxt_idx;
    mtsc_pkg::idx_t              k_far_idx;
    mtsc_pkg::word_t             tw_x;
    mtsc_pkg::word_t             tw_xa;
    mtsc_pkg::word_t             seed_word;
    logic [mtsc_pkg::BYTE_W-1:0] ks_byte;

    mtsc_state_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign accept    = data.valid && (state_reg == mtsc_pkg::ST_IDLE);
    assign reseed    = data.start_of_message || !seeded_reg;
    assign out_free  = !out_valid_reg || result.ready;
    assign k_nxt_idx = (k_reg == IDX_LAST) ? '0 : k_reg + 1'b1;
    assign k_far_idx = (k_reg < IDX_GAP) ? k_reg + IDX_M : k_reg - IDX_GAP;
    assign tw_x      = (cur_reg & mtsc_pkg::MT_UPPER) | (rd_a & mtsc_pkg::MT_LOWER);
    assign tw_xa     = (tw_x >> 1) ^ (tw_x[0] ? mtsc_pkg::MT_MATRIX : '0);
    assign seed_word = prod_reg + mtsc_pkg::WORD_W'(k_reg);
    // byte 0 is the most significant
    assign ks_byte   = tempered_reg[{~byte_pos_reg, 3'b000} +: mtsc_pkg::BYTE_W];

    assign data.ready   = (state_reg == mtsc_pkg::ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.out_byte = out_byte_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (reseed)
                        state_next = mtsc_pkg::ST_SEED_MUL;
                    else if (byte_pos_reg != 2'd0)
                        state_next = mtsc_pkg::ST_EMIT;
                    else if (word_pos_reg == IDX_FULL)
                        state_next = mtsc_pkg::ST_TW_PRE;
                    else
                        state_next = mtsc_pkg::ST_DRAW_RD;
                end
            end
            mtsc_pkg::ST_SEED_MUL:
                state_next = mtsc_pkg::ST_SEED_WR;
            mtsc_pkg::ST_SEED_WR:
                state_next = (k_reg == IDX_LAST) ? mtsc_pkg::ST_TW_PRE : mtsc_pkg::ST_SEED_MUL;
            mtsc_pkg::ST_TW_PRE:
                state_next = mtsc_pkg::ST_TW_LD;
            mtsc_pkg::ST_TW_LD:
                state_next = mtsc_pkg::ST_TW_WR;
            mtsc_pkg::ST_TW_RD:
                state_next = mtsc_pkg::ST_TW_WR;
            mtsc_pkg::ST_TW_WR:
                state_next = (k_reg == IDX_LAST) ? mtsc_pkg::ST_DRAW_RD : mtsc_pkg::ST_TW_RD;
            mtsc_pkg::ST_DRAW_RD:
                state_next = mtsc_pkg::ST_DRAW_TMP;
            mtsc_pkg::ST_DRAW_TMP:
                state_next = mtsc_pkg::ST_EMIT;
            mtsc_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = mtsc_pkg::ST_IDLE;
            end
            default:
                state_next = mtsc_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        seeded_next    = seeded_reg;
        k_next         = k_reg;
        word_pos_next  = word_pos_reg;
        byte_pos_next  = byte_pos_reg;
        prev_next      = prev_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        tempered_next  = tempered_reg;
        data_next      = data_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !result.ready;

        ram_req.we      = 1'b0;
        ram_req.waddr   = k_reg;
        ram_req.wdata   = seed_word;
        ram_req.raddr_a = k_nxt_idx;
        ram_req.raddr_b = k_far_idx;

        case (state_reg)
            mtsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = data.data_byte;
                    if (reseed)
                    begin
                        // word 0 is the key itself
                        ram_req.we    = 1'b1;
                        ram_req.waddr = '0;
                        ram_req.wdata = mtsc_pkg::WORD_W'(key_reg);
                        prev_next     = mtsc_pkg::WORD_W'(key_reg);
                        k_next        = mtsc_pkg::IDX_W'(1);
                        seeded_next   = 1'b1;
                        word_pos_next = IDX_FULL;
                        byte_pos_next = 2'd0;
                    end
                end
            end
            mtsc_pkg::ST_SEED_MUL:
                prod_next = mtsc_pkg::MT_INIT_MUL * (prev_reg ^ (prev_reg >> 30));
            mtsc_pkg::ST_SEED_WR:
            begin
                ram_req.we = 1'b1;
                prev_next  = seed_word;
                k_next     = (k_reg == IDX_LAST) ? '0 : k_reg + 1'b1;
            end
            mtsc_pkg::ST_TW_PRE:
                ram_req.raddr_a = '0;
            mtsc_pkg::ST_TW_LD:
                cur_next = rd_a;
            mtsc_pkg::ST_TW_WR:
            begin
                // words past the current index still hold their old value
                ram_req.we    = 1'b1;
                ram_req.wdata = rd_b ^ tw_xa;
                cur_next      = rd_a;
                if (k_reg == IDX_LAST)
                begin
                    k_next        = '0;
                    word_pos_next = '0;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            mtsc_pkg::ST_DRAW_RD:
                ram_req.raddr_a = word_pos_reg;
            mtsc_pkg::ST_DRAW_TMP:
            begin
                tempered_next = mtsc_pkg::temper(rd_a);
                word_pos_next = word_pos_reg + 1'b1;
            end
            mtsc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_byte_next  = data_reg ^ ks_byte;
                    out_valid_next = 1'b1;
                    byte_pos_next  = byte_pos_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtsc_pkg::ST_IDLE;
            key_reg       <= '0;
            seeded_reg    <= 1'b0;
            k_reg         <= '0;
            word_pos_reg  <= IDX_FULL;
            byte_pos_reg  <= 2'd0;
            tempered_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            k_reg         <= k_next;
            word_pos_reg  <= word_pos_next;
            byte_pos_reg  <= byte_pos_next;
            tempered_reg  <= tempered_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                key_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        prod_reg     <= prod_next;
        cur_reg      <= cur_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

`default_nettype wire
